@@ design/owcc_pkg.sv @@
// shared constants and types for the overlay window clip and crop block
package owcc_pkg;

   localparam int FRAC_BITS = 20;
   localparam int MIN_CROP  = 8;
   localparam int MIN_WIN   = 16;
   localparam int DIV_BITS  = 32;

   typedef enum logic [2:0] {
      CSR_BOUND_LEFT   = 3'd0,
      CSR_BOUND_TOP    = 3'd1,
      CSR_BOUND_RIGHT  = 3'd2,
      CSR_BOUND_BOTTOM = 3'd3,
      CSR_SCAN_MASK    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
      logic [11:0]        scan_mask;
   } bounds_type;

   // per-item data that rides alongside the dividers
   typedef struct packed {
      logic               err;
      logic signed [15:0] odl;
      logic signed [15:0] odt;
      logic signed [15:0] odr;
      logic signed [15:0] odb;
      logic [15:0]        offl;
      logic [15:0]        offt;
      logic [15:0]        offr;
      logic [15:0]        offb;
      logic [11:0]        sw;
      logic [11:0]        sh;
      logic [15:0]        pitch;
      logic [11:0]        cl;
      logic [11:0]        ct;
      logic [11:0]        cr;
      logic [11:0]        cb;
   } side_type;

endpackage

@@ design/owcc_front.sv @@
// front stage: size checks, clip margins, clipped window and divider operands
module owcc_front import owcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] dst_left,
   input  logic signed [15:0] dst_top,
   input  logic signed [15:0] dst_right,
   input  logic signed [15:0] dst_bottom,
   input  logic [11:0]        src_width,
   input  logic [11:0]        src_height,
   input  logic [15:0]        src_pitch,
   input  logic [11:0]        crop_left,
   input  logic [11:0]        crop_top,
   input  logic [11:0]        crop_right,
   input  logic [11:0]        crop_bottom,
   input  bounds_type         bounds,
   output logic               out_valid,
   output side_type           out_side,
   output logic [31:0]        num_h,
   output logic [15:0]        den_h,
   output logic [31:0]        num_v,
   output logic [15:0]        den_v
);

   logic signed [12:0] cw, ch;
   logic signed [16:0] dw, dh;
   logic signed [16:0] ml, mt, mr, mb;
   logic [15:0]        offl, offt, offr, offb;
   logic               too_small, offscr;
   side_type           side_in;
   logic               valid_ff;
   side_type           side_ff;
   logic [31:0]        num_h_ff, num_v_ff;
   logic [15:0]        den_h_ff, den_v_ff;

   always_comb begin
      cw = $signed({1'b0, crop_right}) - $signed({1'b0, crop_left});
      ch = $signed({1'b0, crop_bottom}) - $signed({1'b0, crop_top});
      dw = $signed({dst_right[15], dst_right}) - $signed({dst_left[15], dst_left});
      dh = $signed({dst_bottom[15], dst_bottom}) - $signed({dst_top[15], dst_top});
      ml = $signed({bounds.left[15], bounds.left}) - $signed({dst_left[15], dst_left});
      mt = $signed({bounds.top[15], bounds.top}) - $signed({dst_top[15], dst_top});
      mr = $signed({dst_right[15], dst_right}) - $signed({bounds.right[15], bounds.right});
      mb = $signed({dst_bottom[15], dst_bottom})
         - $signed({bounds.bottom[15], bounds.bottom});
      offl = (ml > 17'sd0) ? ml[15:0] : 16'd0;
      offt = (mt > 17'sd0) ? mt[15:0] : 16'd0;
      offr = (mr > 17'sd0) ? mr[15:0] : 16'd0;
      offb = (mb > 17'sd0) ? mb[15:0] : 16'd0;
      too_small = (cw < $signed(13'(MIN_CROP))) || (ch < $signed(13'(MIN_CROP)))
               || (dw < $signed(17'(MIN_WIN))) || (dh < $signed(17'(MIN_WIN)));
      offscr = ($signed({2'b00, offt}) >= $signed({dh[16], dh}))
            || ($signed({2'b00, offl}) >= $signed({dw[16], dw}))
            || ($signed({2'b00, offb}) >= $signed({dh[16], dh}))
            || ($signed({2'b00, offr}) >= $signed({dw[16], dw}));
      side_in.err   = too_small || offscr;
      side_in.odl   = dst_left + $signed(offl);
      side_in.odt   = dst_top + $signed(offt);
      side_in.odr   = dst_right - $signed(offr);
      side_in.odb   = dst_bottom - $signed(offb);
      side_in.offl  = offl;
      side_in.offt  = offt;
      side_in.offr  = offr;
      side_in.offb  = offb;
      side_in.sw    = src_width;
      side_in.sh    = src_height;
      side_in.pitch = src_pitch;
      side_in.cl    = crop_left;
      side_in.ct    = crop_top;
      side_in.cr    = crop_right;
      side_in.cb    = crop_bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= side_in;
         num_h_ff <= {cw[11:0], {FRAC_BITS{1'b0}}};
         num_v_ff <= {ch[11:0], {FRAC_BITS{1'b0}}};
         den_h_ff <= dw[15:0];
         den_v_ff <= dh[15:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign num_h     = num_h_ff;
   assign num_v     = num_v_ff;
   assign den_h     = den_h_ff;
   assign den_v     = den_v_ff;

endmodule

@@ design/owcc_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
module owcc_divider import owcc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] num,
   input  logic [15:0] den,
   output logic [31:0] quot
);

   logic [31:0] num_ff [0:DIV_BITS-1];
   logic [15:0] den_ff [0:DIV_BITS-1];
   logic [15:0] rem_ff [0:DIV_BITS-1];
   logic [31:0] q_ff   [0:DIV_BITS-1];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
      logic [31:0] num_c;
      logic [15:0] den_c;
      logic [15:0] rem_c;
      logic [31:0] q_c;
      logic [16:0] trial;
      logic        fits;

      if (k == 0) begin : g_first
         assign num_c = num;
         assign den_c = den;
         assign rem_c = 16'd0;
         assign q_c   = 32'd0;
      end else begin : g_next
         assign num_c = num_ff[k-1];
         assign den_c = den_ff[k-1];
         assign rem_c = rem_ff[k-1];
         assign q_c   = q_ff[k-1];
      end

      assign trial = {rem_c, num_c[31]};
      assign fits  = trial >= {1'b0, den_c};

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= {num_c[30:0], 1'b0};
            den_ff[k] <= den_c;
            rem_ff[k] <= fits ? 16'(trial - {1'b0, den_c}) : trial[15:0];
            q_ff[k]   <= {q_c[30:0], fits};
         end
      end
   end

   assign quot = q_ff[DIV_BITS-1];

endmodule

@@ design/owcc_back.sv @@
// back stages: crop amounts, buffer offset, alignment and result register
module owcc_back import owcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  side_type           in_side,
   input  logic [31:0]        hs,
   input  logic [31:0]        vs,
   input  logic [11:0]        scan_mask,
   output logic               out_valid,
   output logic               status,
   output logic signed [15:0] out_dst_left,
   output logic signed [15:0] out_dst_top,
   output logic signed [15:0] out_dst_right,
   output logic signed [15:0] out_dst_bottom,
   output logic signed [16:0] out_src_width,
   output logic signed [16:0] out_src_height,
   output logic [31:0]        buf_start_offset
);

   logic [47:0] pl, pr, pt, pb;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   side_type    s1_ff, s2_ff, s3_ff;
   logic [11:0] kl1_ff, kr1_ff, kt1_ff, kb1_ff;
   logic [12:0] kl2_in, kt2_in, kl2_ff, kt2_ff, kl3_ff, kt3_ff;
   logic signed [14:0] kr2_in, kb2_in, kr2_ff, kb2_ff, kr3_ff, kb3_ff;
   logic [31:0] off3_in, off3_ff;
   logic [11:0] masked;
   logic signed [17:0] kl4, w4, h4;
   logic        st_ff;
   logic signed [15:0] odl_ff, odt_ff, odr_ff, odb_ff;
   logic signed [16:0] w_ff, h_ff;
   logic [31:0] off_ff;

   // scaled margins, the 12 integer bits of each product
   assign pl = {32'd0, in_side.offl} * {16'd0, hs};
   assign pr = {32'd0, in_side.offr} * {16'd0, hs};
   assign pt = {32'd0, in_side.offt} * {16'd0, vs};
   assign pb = {32'd0, in_side.offb} * {16'd0, vs};

   always_comb begin
      kl2_in = {1'b0, kl1_ff} + {1'b0, s1_ff.cl};
      kt2_in = {1'b0, kt1_ff} + {1'b0, s1_ff.ct};
      // right crop takes one more pixel than the bottom crop takes lines
      kr2_in = $signed({3'b000, kr1_ff}) + $signed({3'b000, s1_ff.sw})
             - $signed({3'b000, s1_ff.cr}) - 15'sd1;
      kb2_in = $signed({3'b000, kb1_ff}) + $signed({3'b000, s1_ff.sh})
             - $signed({3'b000, s1_ff.cb});
      off3_in = 32'(kt2_ff) * 32'(s2_ff.pitch) + 32'({kl2_ff, 1'b0});
   end

   always_comb begin
      masked = off3_ff[11:0] & scan_mask;
      kl4 = $signed({5'd0, kl3_ff}) - $signed({7'd0, masked[11:1]});
      w4  = $signed({6'd0, s3_ff.sw}) - (kl4 + 18'(kr3_ff));
      h4  = $signed({6'd0, s3_ff.sh}) - ($signed({5'd0, kt3_ff}) + 18'(kb3_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= in_side;
         kl1_ff <= pl[FRAC_BITS+11:FRAC_BITS];
         kr1_ff <= pr[FRAC_BITS+11:FRAC_BITS];
         kt1_ff <= pt[FRAC_BITS+11:FRAC_BITS];
         kb1_ff <= pb[FRAC_BITS+11:FRAC_BITS];
         s2_ff  <= s1_ff;
         kl2_ff <= kl2_in;
         kt2_ff <= kt2_in;
         kr2_ff <= kr2_in;
         kb2_ff <= kb2_in;
         s3_ff  <= s2_ff;
         kl3_ff <= kl2_ff;
         kt3_ff <= kt2_ff;
         kr3_ff <= kr2_ff;
         kb3_ff <= kb2_ff;
         off3_ff <= off3_in;
         // an error result carries zero in every field but the status
         st_ff  <= s3_ff.err;
         odl_ff <= s3_ff.err ? 16'sd0 : s3_ff.odl;
         odt_ff <= s3_ff.err ? 16'sd0 : s3_ff.odt;
         odr_ff <= s3_ff.err ? 16'sd0 : s3_ff.odr;
         odb_ff <= s3_ff.err ? 16'sd0 : s3_ff.odb;
         w_ff   <= s3_ff.err ? 17'sd0 : w4[16:0];
         h_ff   <= s3_ff.err ? 17'sd0 : h4[16:0];
         off_ff <= s3_ff.err ? 32'd0 : (off3_ff & ~{20'd0, scan_mask});
      end
   end

   assign out_valid        = v4_ff;
   assign status           = st_ff;
   assign out_dst_left     = odl_ff;
   assign out_dst_top      = odt_ff;
   assign out_dst_right    = odr_ff;
   assign out_dst_bottom   = odb_ff;
   assign out_src_width    = w_ff;
   assign out_src_height   = h_ff;
   assign buf_start_offset = off_ff;

endmodule

@@ design/overlay_window_clip_crop.sv @@
// top level of the overlay window clip and crop pipeline
//
// one overlay setup enters on the req_ channel, one result leaves on rsp_.
// an item is taken at a clock edge with valid high and stall low.
// csr_ writes set the visible bounds and the scan alignment mask; write them
// only while no item is in flight.
// the pipeline has one check stage, 32 divider stages (one quotient bit
// each, both inverse scale factors in parallel) and four crop/offset stages.
// throughput is one item per cycle while no output stall holds the pipeline.
// all stages advance together; while rsp_valid is high and rsp_stall is high
// the whole pipeline holds and req_stall is raised, so the waiting result and
// every item behind it stay put.
// reset clears all valid bits and sets the bounds and mask to zero.
// status 1 marks a rejected setup (crop under 8, window under 16, or window
// wholly off screen); all other fields are zero then.
module overlay_window_clip_crop import owcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_dst_left,
   input  logic signed [15:0] req_dst_top,
   input  logic signed [15:0] req_dst_right,
   input  logic signed [15:0] req_dst_bottom,
   input  logic [11:0]        req_src_width,
   input  logic [11:0]        req_src_height,
   input  logic [15:0]        req_src_pitch,
   input  logic [11:0]        req_crop_left,
   input  logic [11:0]        req_crop_top,
   input  logic [11:0]        req_crop_right,
   input  logic [11:0]        req_crop_bottom,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic signed [15:0] rsp_out_dst_left,
   output logic signed [15:0] rsp_out_dst_top,
   output logic signed [15:0] rsp_out_dst_right,
   output logic signed [15:0] rsp_out_dst_bottom,
   output logic signed [16:0] rsp_out_src_width,
   output logic signed [16:0] rsp_out_src_height,
   output logic [31:0]        rsp_buf_start_offset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   bounds_type  bounds_ff;
   logic        en;
   logic        fv;
   side_type    fside;
   logic [31:0] num_h, num_v, hs, vs;
   logic [15:0] den_h, den_v;
   logic        vd_ff [0:DIV_BITS-1];
   side_type    sd_ff [0:DIV_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BOUND_LEFT:   bounds_ff.left      <= csr_data;
            CSR_BOUND_TOP:    bounds_ff.top       <= csr_data;
            CSR_BOUND_RIGHT:  bounds_ff.right     <= csr_data;
            CSR_BOUND_BOTTOM: bounds_ff.bottom    <= csr_data;
            CSR_SCAN_MASK:    bounds_ff.scan_mask <= csr_data[11:0];
            default: begin
            end
         endcase
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   owcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .dst_left   (req_dst_left),
      .dst_top    (req_dst_top),
      .dst_right  (req_dst_right),
      .dst_bottom (req_dst_bottom),
      .src_width  (req_src_width),
      .src_height (req_src_height),
      .src_pitch  (req_src_pitch),
      .crop_left  (req_crop_left),
      .crop_top   (req_crop_top),
      .crop_right (req_crop_right),
      .crop_bottom(req_crop_bottom),
      .bounds     (bounds_ff),
      .out_valid  (fv),
      .out_side   (fside),
      .num_h      (num_h),
      .den_h      (den_h),
      .num_v      (num_v),
      .den_v      (den_v)
   );

   owcc_divider u_div_h (
      .clock (clock),
      .en    (en),
      .num   (num_h),
      .den   (den_h),
      .quot  (hs)
   );

   owcc_divider u_div_v (
      .clock (clock),
      .en    (en),
      .num   (num_v),
      .den   (den_v),
      .quot  (vs)
   );

   // side data delay matching the divider depth
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (en) begin
            vd_ff[k] <= (k == 0) ? fv : vd_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[k] <= (k == 0) ? fside : sd_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   owcc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (vd_ff[DIV_BITS-1]),
      .in_side          (sd_ff[DIV_BITS-1]),
      .hs               (hs),
      .vs               (vs),
      .scan_mask        (bounds_ff.scan_mask),
      .out_valid        (rsp_valid),
      .status           (rsp_status),
      .out_dst_left     (rsp_out_dst_left),
      .out_dst_top      (rsp_out_dst_top),
      .out_dst_right    (rsp_out_dst_right),
      .out_dst_bottom   (rsp_out_dst_bottom),
      .out_src_width    (rsp_out_src_width),
      .out_src_height   (rsp_out_src_height),
      .buf_start_offset (rsp_buf_start_offset)
   );

endmodule

@@ design/owcc_checker.sv @@
// port-level checks for the overlay window clip and crop block, with bind
module owcc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_status,
   input logic signed [15:0] rsp_out_dst_left,
   input logic signed [15:0] rsp_out_dst_right,
   input logic signed [16:0] rsp_out_src_width,
   input logic [31:0]        rsp_buf_start_offset
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

   // a rejected setup carries zeros
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_out_dst_left == 16'sd0
         && rsp_out_dst_right == 16'sd0 && rsp_out_src_width == 17'sd0
         && rsp_buf_start_offset == 32'd0)
      else $error("error result with nonzero fields");

   // the input holds exactly when a result waits on the stalled side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall out of step with output");

endmodule

bind overlay_window_clip_crop owcc_checker u_owcc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_out_dst_left     (rsp_out_dst_left),
   .rsp_out_dst_right    (rsp_out_dst_right),
   .rsp_out_src_width    (rsp_out_src_width),
   .rsp_buf_start_offset (rsp_buf_start_offset)
);

@@ test/overlay_window_clip_crop_tb.sv @@
// testbench for the overlay window clip and crop pipeline
`timescale 1ns / 100ps

module overlay_window_clip_crop_tb;
   import owcc_pkg::*;

   localparam int LATENCY     = 37;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 80;

   typedef struct packed {
      logic signed [15:0] dst_left;
      logic signed [15:0] dst_top;
      logic signed [15:0] dst_right;
      logic signed [15:0] dst_bottom;
      logic [11:0]        src_width;
      logic [11:0]        src_height;
      logic [15:0]        src_pitch;
      logic [11:0]        crop_left;
      logic [11:0]        crop_top;
      logic [11:0]        crop_right;
      logic [11:0]        crop_bottom;
   } setup_type;

   typedef struct packed {
      logic               status;
      logic signed [15:0] dst_left;
      logic signed [15:0] dst_top;
      logic signed [15:0] dst_right;
      logic signed [15:0] dst_bottom;
      logic signed [16:0] src_width;
      logic signed [16:0] src_height;
      logic [31:0]        start_offset;
   } clip_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_dst_left, req_dst_top, req_dst_right, req_dst_bottom;
   logic [11:0]        req_src_width, req_src_height;
   logic [15:0]        req_src_pitch;
   logic [11:0]        req_crop_left, req_crop_top, req_crop_right, req_crop_bottom;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_status;
   logic signed [15:0] rsp_out_dst_left, rsp_out_dst_top;
   logic signed [15:0] rsp_out_dst_right, rsp_out_dst_bottom;
   logic signed [16:0] rsp_out_src_width, rsp_out_src_height;
   logic [31:0]        rsp_buf_start_offset;
   logic               csr_write;
   csr_index_type      csr_index;
   logic [15:0]        csr_data;

   // shadow of the bound and mask registers
   logic signed [15:0] vis_left, vis_top, vis_right, vis_bottom;
   logic [11:0]        vis_mask;

   setup_type setup_queue[$];
   clip_type  clip_queue[$];
   int        mismatches;
   int        cycles;
   bit        no_idle;
   int        hold_asked, hold_seen;
   bit        req_taken, rsp_taken;
   int        req_gap, rsp_gap, hold_left;

   overlay_window_clip_crop i_dut (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint clip_margin(longint a, longint b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic clip_type clip_setup(setup_type s);
      clip_type r;
      longint dl, dt, dr, db, cw, ch, dw, dh;
      longint hs, vs, offl, offt, offr, offb, kl, kt, kr, kb, off;
      r = '0;
      r.status = 1'b1;
      dl = s.dst_left;  dt = s.dst_top;  dr = s.dst_right;  db = s.dst_bottom;
      cw = longint'(s.crop_right) - longint'(s.crop_left);
      ch = longint'(s.crop_bottom) - longint'(s.crop_top);
      dw = dr - dl;
      dh = db - dt;
      if (cw < MIN_CROP || ch < MIN_CROP || dh < MIN_WIN || dw < MIN_WIN) return r;
      hs = (cw << FRAC_BITS) / dw;
      vs = (ch << FRAC_BITS) / dh;
      offt = clip_margin(vis_top, dt);
      offl = clip_margin(vis_left, dl);
      offr = clip_margin(dr, vis_right);
      offb = clip_margin(db, vis_bottom);
      if (offt >= dh || offl >= dw || offb >= dh || offr >= dw) return r;
      kl = ((offl * hs) >>> FRAC_BITS) + s.crop_left;
      kr = ((offr * hs) >>> FRAC_BITS) + longint'(s.src_width) - s.crop_right - 1;
      kt = ((offt * vs) >>> FRAC_BITS) + s.crop_top;
      kb = ((offb * vs) >>> FRAC_BITS) + longint'(s.src_height) - s.crop_bottom;
      off = kt * longint'(s.src_pitch) + kl * 2;
      // masked-off bytes are handed back to the left crop
      kl = kl - (off & longint'(vis_mask)) / 2;
      off = off & ~longint'(vis_mask);
      r.status       = 1'b0;
      r.dst_left     = 16'(dl + offl);
      r.dst_top      = 16'(dt + offt);
      r.dst_right    = 16'(dr - offr);
      r.dst_bottom   = 16'(db - offb);
      r.src_width    = 17'(longint'(s.src_width) - (kl + kr));
      r.src_height   = 17'(longint'(s.src_height) - (kt + kb));
      r.start_offset = 32'(off);
      return r;
   endfunction

   // sender
   always @(negedge clock) begin
      setup_type s;
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the offered item
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (setup_queue.size() > 0) begin
            s = setup_queue.pop_front();
            {req_dst_left, req_dst_top, req_dst_right, req_dst_bottom, req_src_width,
             req_src_height, req_src_pitch, req_crop_left, req_crop_top, req_crop_right,
             req_crop_bottom} <= s;
            req_valid <= 1'b1;
            req_gap <= no_idle ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with an occasional long hold-off
   always @(negedge clock) begin
      int wait_now;
      if (!reset) begin
         wait_now = rsp_gap;
         if (rsp_taken) wait_now = no_idle ? 0 : $urandom_range(0, 9);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (wait_now > 0) begin
            rsp_stall <= 1'b1;
            wait_now = wait_now - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
         rsp_gap <= wait_now;
      end
   end

   // predictor and checker
   always @(posedge clock) begin
      clip_type got, want;
      cycles <= cycles + 1;
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall)
         clip_queue.push_back(clip_setup({req_dst_left, req_dst_top, req_dst_right,
            req_dst_bottom, req_src_width, req_src_height, req_src_pitch, req_crop_left,
            req_crop_top, req_crop_right, req_crop_bottom}));
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_out_dst_left, rsp_out_dst_top, rsp_out_dst_right,
                rsp_out_dst_bottom, rsp_out_src_width, rsp_out_src_height,
                rsp_buf_start_offset};
         if (clip_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", got);
         end else begin
            want = clip_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("overlay_window_clip_crop_tb: errors");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_BOUND_LEFT:   vis_left   = value;
         CSR_BOUND_TOP:    vis_top    = value;
         CSR_BOUND_RIGHT:  vis_right  = value;
         CSR_BOUND_BOTTOM: vis_bottom = value;
         default:          vis_mask   = value[11:0];
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_bounds(int l, int t, int r, int b, int mask);
      write_csr(CSR_BOUND_LEFT, 16'(l));
      write_csr(CSR_BOUND_TOP, 16'(t));
      write_csr(CSR_BOUND_RIGHT, 16'(r));
      write_csr(CSR_BOUND_BOTTOM, 16'(b));
      write_csr(CSR_SCAN_MASK, 16'(mask));
   endtask

   task automatic wait_drained();
      while (setup_queue.size() > 0 || req_valid || clip_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic setup_type make_setup(int l, int t, int r, int b, int sw, int sh,
                                            int pitch, int cl, int ct, int cr, int cb);
      return {16'(l), 16'(t), 16'(r), 16'(b), 12'(sw), 12'(sh), 16'(pitch),
              12'(cl), 12'(ct), 12'(cr), 12'(cb)};
   endfunction

   function automatic int clamp16(int v);
      return (v > 32767) ? 32767 : v;
   endfunction

   // mostly well-formed setups near the visible area, some pure noise
   task automatic add_random(int count);
      setup_type s;
      logic [159:0] noise;
      int l, t, cl, ct;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            s = noise[151:0];
         end else begin
            l  = int'(vis_left) + $urandom_range(0, 600) - 300;
            t  = int'(vis_top) + $urandom_range(0, 600) - 300;
            if (l > 32000) l = 32000;
            if (t > 32000) t = 32000;
            cl = $urandom_range(0, 4080);
            ct = $urandom_range(0, 4080);
            s = make_setup(l, t, clamp16(l + $urandom_range(16, 3000)),
                           clamp16(t + $urandom_range(16, 3000)), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 65535), cl, ct,
                           cl + $urandom_range(8, 4095 - cl), ct + $urandom_range(8, 4095 - ct));
         end
         setup_queue.push_back(s);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_dst_left, req_dst_top, req_dst_right, req_dst_bottom, req_src_width,
       req_src_height, req_src_pitch, req_crop_left, req_crop_top, req_crop_right,
       req_crop_bottom} = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_BOUND_LEFT;
      csr_data = '0;
      {vis_left, vis_top, vis_right, vis_bottom, vis_mask} = '0;
      mismatches = 0;
      cycles = 0;
      no_idle = 1'b0;
      hold_asked = 0;
      hold_seen = 0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      hold_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_bounds(0, 0, 1919, 1079, 63);
      // directed: limits of crop and window size, off screen on each side, extremes
      setup_queue.push_back(make_setup(100, 100, 500, 400, 640, 480, 1280, 0, 0, 7, 100));
      setup_queue.push_back(make_setup(100, 100, 500, 400, 640, 480, 1280, 0, 0, 100, 7));
      setup_queue.push_back(make_setup(100, 100, 500, 400, 640, 480, 1280, 10, 10, 18, 18));
      setup_queue.push_back(make_setup(100, 100, 115, 400, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(100, 100, 500, 115, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(100, 100, 116, 116, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(100, 100, 500, 400, 640, 480, 1280, 50, 0, 10, 480));
      setup_queue.push_back(make_setup(-600, 100, -100, 400, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(-499, 100, 1, 400, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(100, -600, 500, -100, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(1920, 100, 2400, 400, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(100, 1079, 500, 1500, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(-200, -150, 2100, 1200, 640, 480, 1280, 0, 0, 640, 480));
      setup_queue.push_back(make_setup(-32768, -32768, 32767, 32767, 4095, 4095, 65535,
                                       0, 0, 4095, 4095));
      setup_queue.push_back(make_setup(32767, 32767, -32768, -32768, 4095, 4095, 65535,
                                       4095, 4095, 0, 0));
      setup_queue.push_back(make_setup(3, 5, 1000, 900, 0, 0, 0, 3, 5, 1000, 900));
      setup_queue.push_back(make_setup(-7, -9, 1800, 1000, 4095, 4095, 65535,
                                       4087, 4087, 4095, 4095));
      setup_queue.push_back(make_setup(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      // receiver holds off while the sender keeps offering
      set_bounds(-32768, -32768, 32767, 32767, 4095);
      hold_asked = hold_asked + 1;
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      set_bounds(32767, 32767, -32768, -32768, 0);
      no_idle = 1'b1;
      add_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      no_idle = 1'b0;

      set_bounds(-100, 50, 800, 600, 5);
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      set_bounds($urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(800, 3000),
                 $urandom_range(800, 3000), $urandom_range(0, 4095));
      no_idle = 1'b1;
      add_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      no_idle = 1'b0;
      add_random(RANDOM_PER_PHASE);
      wait_drained();

      if (mismatches == 0 && clip_queue.size() == 0) begin
         $display("overlay_window_clip_crop_tb: clean");
      end else begin
         $display("overlay_window_clip_crop_tb: errors");
      end
      $finish;
   end

endmodule
